// File: design/assert_macros.svh
// Assertion macros for the checker file spq_check.sv.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SPQ_ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
        else $error("spq assertion failed");

// Concurrent assertion on clk and rst_n of the enclosing scope.
`define SPQ_ASSERT(lbl, prop) \
    `SPQ_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// File: design/spq_pkg.sv
// Package for the strict-priority ten-class queue: sizes, payload types,
// state and status codes, and class mapping helpers. Depends on nothing.
package spq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int ID_WIDTH     = 18;
    localparam int NUM_CLASSES  = 10;
    localparam int NUM_RISKS    = 5;
    localparam int OUT_ID_W     = 18;
    localparam int POS_W        = 16;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [2:0]       RISK_MAX = 3'(NUM_RISKS - 1);

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_ENQ   = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_DEQ   = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Operation codes of the func field.
    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    // Control states of the top level.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic        func;
        logic        by_law_priority;
        logic [2:0]  risk_level;
        logic [17:0] patient_id;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [17:0] served_id;
        logic        served_by_law;
        logic [2:0]  served_risk;
        logic [15:0] position;
    } out_item_t;

    // Outcome of the strict-priority search.
    typedef struct packed {
        logic             any;
        logic [CLS_W-1:0] cls;
    } sel_t;

    // Class index: legal-priority group first, risk saturated to the last level.
    function automatic logic [CLS_W-1:0] class_of(input logic by_law,
                                                  input logic [2:0] risk);
        logic [2:0] r;
        r = (risk > RISK_MAX) ? RISK_MAX : risk;
        return by_law ? CLS_W'(r) : CLS_W'(r) + CLS_W'(NUM_RISKS);
    endfunction

    function automatic logic class_by_law(input logic [CLS_W-1:0] cls);
        return cls < CLS_W'(NUM_RISKS);
    endfunction

    function automatic logic [2:0] class_risk(input logic [CLS_W-1:0] cls);
        logic [CLS_W-1:0] r;
        r = (cls < CLS_W'(NUM_RISKS)) ? cls : cls - CLS_W'(NUM_RISKS);
        return r[2:0];
    endfunction

    // Stored identifier from the input field, keeping the low ID_WIDTH bits.
    function automatic logic [ID_WIDTH-1:0] id_in(input logic [17:0] pid);
        logic [63:0] w;
        w = 64'(pid);
        return w[ID_WIDTH-1:0];
    endfunction

    // Result identifier from a stored one, keeping the low 18 bits.
    function automatic logic [OUT_ID_W-1:0] id_out(input logic [ID_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_ID_W-1:0];
    endfunction

    // Ring pointer step with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Flat store address of a class slot.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

// File: design/strict_priority_ten_class_queue.sv
// Top level of the strict-priority ten-class queue: class pointers, counts,
// serve counter, control and output register. Depends on spq_pkg, spq_ram, spq_sel.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (spq_pkg::in_item_t)
//  out     | output    | out_valid / out_ready| out_data (spq_pkg::out_item_t)
//
// An enqueue, a full report or an empty report goes straight into the output register.
// A successful dequeue reads the identifier store, whose read data is registered, then passes through ST_READ.
// Input is taken when the control is idle and the output register is empty or draining.
// Reset clears pointers, counts and the serve counter at once; the store needs no clearing.
// A stalled output holds its result; new input waits until that result moves.
module strict_priority_ten_class_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output spq_pkg::out_item_t out_data
);

    localparam int NC = spq_pkg::NUM_CLASSES;

    spq_pkg::state_t state_reg, state_next;

    logic [spq_pkg::PTR_W-1:0] head_reg [NC];
    logic [spq_pkg::PTR_W-1:0] head_next [NC];
    logic [spq_pkg::PTR_W-1:0] tail_reg [NC];
    logic [spq_pkg::PTR_W-1:0] tail_next [NC];
    logic [spq_pkg::CNT_W-1:0] count_reg [NC];
    logic [spq_pkg::CNT_W-1:0] count_next [NC];

    logic [spq_pkg::POS_W-1:0] serve_reg, serve_next;
    logic [spq_pkg::POS_W-1:0] pend_pos_reg, pend_pos_next;
    logic [spq_pkg::CLS_W-1:0] pend_cls_reg, pend_cls_next;

    logic               out_valid_reg, out_valid_next;
    spq_pkg::out_item_t out_data_reg, out_data_next;

    logic                       accept;
    logic                       is_deq;
    logic                       out_free;
    logic [NC-1:0]              nonempty;
    spq_pkg::sel_t              sel;
    logic [spq_pkg::CLS_W-1:0]  enq_cls;
    logic                       enq_full;
    logic                       mem_we;
    logic                       mem_re;
    logic [spq_pkg::ADDR_W-1:0] mem_waddr;
    logic [spq_pkg::ADDR_W-1:0] mem_raddr;
    logic [spq_pkg::ID_WIDTH-1:0] mem_rdata;

    // Occupancy flags feed the priority search.
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    spq_sel u_sel (
        .nonempty (nonempty),
        .sel      (sel)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_deq   = (in_data.func == spq_pkg::FUNC_DEQ);
    assign enq_cls  = spq_pkg::class_of(in_data.by_law_priority, in_data.risk_level);
    assign enq_full = (count_reg[enq_cls] == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept && is_deq && sel.any)
                begin
                    state_next = spq_pkg::ST_READ;
                end
            end
            spq_pkg::ST_READ:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE: in_ready = out_free;
            spq_pkg::ST_READ: in_ready = 1'b0;
            default:          in_ready = 1'b0;
        endcase
    end

    // Store accesses: write on an accepted enqueue, read the chosen head on a dequeue.
    assign mem_we    = accept && !is_deq && !enq_full;
    assign mem_waddr = spq_pkg::slot_addr(enq_cls, tail_reg[enq_cls]);
    assign mem_re    = accept && is_deq && sel.any;
    assign mem_raddr = spq_pkg::slot_addr(sel.cls, head_reg[sel.cls]);

    spq_ram #(
        .WIDTH (spq_pkg::ID_WIDTH),
        .DEPTH (spq_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (spq_pkg::id_in(in_data.patient_id)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Pointer, count and counter updates, plus the result register.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        serve_next     = serve_reg;
        pend_pos_next  = pend_pos_reg;
        pend_cls_next  = pend_cls_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (accept)
        begin
            if (!is_deq)
            begin
                out_data_next = '0;
                out_valid_next = 1'b1;
                if (enq_full)
                begin
                    out_data_next.status = spq_pkg::STAT_FULL;
                end
                else
                begin
                    out_data_next.status = spq_pkg::STAT_ENQ;
                    tail_next[enq_cls]  = spq_pkg::ptr_adv(tail_reg[enq_cls]);
                    count_next[enq_cls] = count_reg[enq_cls] + spq_pkg::CNT_W'(1);
                end
            end
            else if (!sel.any)
            begin
                out_data_next = '0;
                out_data_next.status = spq_pkg::STAT_EMPTY;
                out_valid_next = 1'b1;
                serve_next = '0;
            end
            else
            begin
                head_next[sel.cls]  = spq_pkg::ptr_adv(head_reg[sel.cls]);
                count_next[sel.cls] = count_reg[sel.cls] - spq_pkg::CNT_W'(1);
                serve_next = (serve_reg == spq_pkg::POS_MAX)
                             ? serve_reg
                             : serve_reg + spq_pkg::POS_W'(1);
                pend_pos_next = serve_next;
                pend_cls_next = sel.cls;
            end
        end

        // Identifier arrives from the store's registered read port in ST_READ.
        if (state_reg == spq_pkg::ST_READ)
        begin
            out_data_next.status        = spq_pkg::STAT_DEQ;
            out_data_next.served_id     = spq_pkg::id_out(mem_rdata);
            out_data_next.served_by_law = spq_pkg::class_by_law(pend_cls_reg);
            out_data_next.served_risk   = spq_pkg::class_risk(pend_cls_reg);
            out_data_next.position      = pend_pos_reg;
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            serve_reg     <= '0;
            for (int i = 0; i < NC; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            serve_reg     <= serve_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pend_pos_reg <= pend_pos_next;
        pend_cls_reg <= pend_cls_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/spq_sel.sv
// Strict-priority search over the class occupancy flags.
// Depends on spq_pkg.
module spq_sel (
    input  logic [spq_pkg::NUM_CLASSES-1:0] nonempty,
    output spq_pkg::sel_t                   sel
);

    // Lowest-numbered non-empty class wins.
    always_comb
    begin
        sel.any = 1'b0;
        sel.cls = '0;
        for (int i = spq_pkg::NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                sel.any = 1'b1;
                sel.cls = spq_pkg::CLS_W'(i);
            end
        end
    end

endmodule

// File: design/spq_check.sv
// Port-level checker for the strict-priority ten-class queue, with its bind.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input spq_pkg::out_item_t out_data
);

    logic quiet_ok;
    logic deq_ok;

    // Field summaries used by the result checks.
    assign quiet_ok = (out_data.served_id == '0) && (out_data.position == '0)
                      && (out_data.served_risk == '0) && !out_data.served_by_law;
    assign deq_ok   = (out_data.position != '0)
                      && (out_data.served_risk <= spq_pkg::RISK_MAX);

    // A stalled result keeps its valid and its payload.
    `SPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

    // A new transfer in is only taken when the result slot frees up.
    `SPQ_ASSERT(a_in_slot, in_ready |-> !out_valid || out_ready)

    // Only a dequeue result carries an identifier or a position.
    `SPQ_ASSERT(a_quiet_fields, out_valid && out_data.status != spq_pkg::STAT_DEQ |-> quiet_ok)

    // A served item has a real position and a valid risk level.
    `SPQ_ASSERT(a_deq_fields, out_valid && out_data.status == spq_pkg::STAT_DEQ |-> deq_ok)

endmodule

bind strict_priority_ten_class_queue spq_check u_spq_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
